// ===== design/pafbf_pkg.sv =====
// ---------------------------------------------------------------------------
// pafbf_pkg: shared types and constants of the partition allocator
// Word formats, outcome and opcode values, and controller/datapath links.
// ---------------------------------------------------------------------------
package pafbf_pkg;

    localparam int MAX_SLOTS  = 8;
    localparam int NUM_BLOCKS = 8;

    localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
    localparam int SIZE_W     = 16;
    localparam int OWNER_W    = 10;
    localparam int COUNT_W    = 4;
    localparam int OUTCOME_W  = 2;

    localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_BLOCKS - 1);

    localparam logic OP_ALLOC     = 1'b0;
    localparam logic OP_RELEASE   = 1'b1;
    localparam logic POLICY_FIRST = 1'b0;
    localparam logic POLICY_BEST  = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_ALLOCATED  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NO_SPACE   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_RELEASED   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NONE_OWNED = 2'd3;

    typedef struct packed {
        logic               op;
        logic               policy;
        logic [OWNER_W-1:0] owner_id;
        logic [SIZE_W-1:0]  request_size;
    } in_word_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0]  outcome;
        logic [SLOT_IDX_W-1:0] chosen_block;
        logic [COUNT_W-1:0]    freed_count;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic                  load;
        logic                  scan;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } status_t;

endpackage

// ===== design/pafbf_ctrl.sv =====
// ---------------------------------------------------------------------------
// pafbf_ctrl: request sequencer
// Takes a request word, steps the block index over all partitions, then
// commits the result once the output register can take it.
// ---------------------------------------------------------------------------
module pafbf_ctrl
    import pafbf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [SLOT_IDX_W-1:0] idx_reg;
    logic [SLOT_IDX_W-1:0] idx_next;
    logic                  can_commit;

    assign can_commit = !status.out_full || out_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free or being drained
                if (can_commit)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (cmd.idx <= LAST_IDX))
        else $error("scan index beyond last block");

    a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && idx_reg == LAST_IDX) |=> (state_reg == ST_DONE))
        else $error("scan did not end in done state");

    a_no_commit_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (status.out_full && !out_ready) |-> !cmd.commit)
        else $error("commit while the output register is held");

endmodule

// ===== design/pafbf_dp.sv =====
// ---------------------------------------------------------------------------
// pafbf_dp: allocator datapath
// Holds partition sizes, busy flags and owners; evaluates one block per scan
// step and writes the result word into the output register on commit.
// ---------------------------------------------------------------------------
module pafbf_dp
    import pafbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_word_t              in_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [SLOT_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  cmd_t                  cmd,
    output status_t               status
);

    logic [SIZE_W-1:0]     size_reg  [MAX_SLOTS];
    logic [OWNER_W-1:0]    owner_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  busy_reg;

    in_word_t              req_reg;
    logic                  found_reg;
    logic [SLOT_IDX_W-1:0] pick_reg;
    logic [SIZE_W-1:0]     pick_size_reg;
    logic [MAX_SLOTS-1:0]  rel_mask_reg;
    logic [COUNT_W-1:0]    freed_reg;

    logic                  out_valid_reg;
    out_word_t             out_reg;
    out_word_t             out_next;

    logic [SIZE_W-1:0]     cur_size;
    logic                  fits;
    logic                  take;
    logic                  hit;

    assign cur_size = size_reg[cmd.idx];
    assign fits     = !busy_reg[cmd.idx] && (cur_size != '0)
                      && (req_reg.request_size <= cur_size);
    assign take     = fits && (req_reg.policy == POLICY_FIRST ? !found_reg
                               : (!found_reg || cur_size <= pick_size_reg));
    assign hit      = busy_reg[cmd.idx] && (owner_reg[cmd.idx] == req_reg.owner_id);

    always_comb
    begin
        out_next = '0;
        if (req_reg.op == OP_ALLOC)
        begin
            if (found_reg)
            begin
                out_next.outcome      = OUT_ALLOCATED;
                out_next.chosen_block = pick_reg;
            end
            else
            begin
                out_next.outcome = OUT_NO_SPACE;
            end
        end
        else
        begin
            out_next.outcome     = (freed_reg != '0) ? OUT_RELEASED : OUT_NONE_OWNED;
            out_next.freed_count = freed_reg;
        end
    end

    // partition sizes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                size_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            size_reg[cfg_index] <= cfg_data;
        end
    end

    // owners: only read behind a busy flag, so no reset
    always_ff @(posedge clk)
    begin
        if (cmd.commit && req_reg.op == OP_ALLOC && found_reg)
        begin
            owner_reg[pick_reg] <= req_reg.owner_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            found_reg     <= 1'b0;
            pick_reg      <= '0;
            pick_size_reg <= '0;
            rel_mask_reg  <= '0;
            freed_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                found_reg    <= 1'b0;
                pick_reg     <= '0;
                rel_mask_reg <= '0;
                freed_reg    <= '0;
            end
            if (cmd.scan)
            begin
                if (req_reg.op == OP_ALLOC)
                begin
                    if (take)
                    begin
                        found_reg     <= 1'b1;
                        pick_reg      <= cmd.idx;
                        pick_size_reg <= cur_size;
                    end
                end
                else if (hit)
                begin
                    rel_mask_reg[cmd.idx] <= 1'b1;
                    freed_reg             <= freed_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                if (req_reg.op == OP_ALLOC)
                begin
                    if (found_reg)
                    begin
                        busy_reg[pick_reg] <= 1'b1;
                    end
                end
                else
                begin
                    busy_reg <= busy_reg & ~rel_mask_reg;
                end
                out_reg       <= out_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign status.out_full = out_valid_reg;

    a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_freed_matches_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.outcome == OUT_RELEASED) == (out_reg.freed_count != '0)))
        else $error("freed count disagrees with outcome");

    a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && req_reg.op == OP_ALLOC && found_reg) |=> busy_reg[$past(pick_reg)])
        else $error("granted block not marked busy");

    a_chosen_only_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.outcome != OUT_ALLOCATED) |-> (out_reg.chosen_block == '0))
        else $error("block index set without a grant");

endmodule

// ===== design/partition_allocator_first_best_fit.sv =====
// ---------------------------------------------------------------------------
// partition_allocator_first_best_fit: fixed-partition allocator top level
// Flow: the input word is taken in the idle state, the scan then evaluates
//   every block in turn, and the result is committed into the output register.
// Throughput: a new word is taken only once the last result is committed and
//   the sequencer is back in idle; a held result stalls the commit.
// Reset: all partition sizes zero, all blocks free, no result pending.
// ---------------------------------------------------------------------------
module partition_allocator_first_best_fit
    import pafbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [SLOT_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    pafbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pafbf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the partition allocator
// Sends allocate and release words with random gaps on both channels,
// predicts each outcome from a local copy of partition sizes, busy flags and
// owners, and checks every result word field by field, in order.
// ---------------------------------------------------------------------------
module tb_top;
    import pafbf_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RUN_LIMIT    = 20_000_000;
    localparam int DRAIN_CYCLES = 30;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_WORDS  = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_word_t             out_data;
    logic                  cfg_we;
    logic [SLOT_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]     cfg_data;

    // local copy of the allocator state
    logic [SIZE_W-1:0]  part_size  [MAX_SLOTS];
    logic               part_busy  [MAX_SLOTS];
    logic [OWNER_W-1:0] part_owner [MAX_SLOTS];

    out_word_t pending_outcomes [$];
    out_word_t oldest_outcome;
    int        mismatch_count;
    bit        sender_gaps_on;
    bit        receiver_stalls_on;

    partition_allocator_first_best_fit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Mismatches found");
        $finish;
    end

    // Grant or release against the local state and return the outcome word.
    function automatic out_word_t apply_request(input in_word_t w);
        out_word_t r;
        logic      found;
        int        pick;
        int        freed;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        freed = 0;
        if (w.op == OP_ALLOC)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if (!part_busy[i] && part_size[i] != '0 && w.request_size <= part_size[i])
                begin
                    if (w.policy == POLICY_FIRST)
                    begin
                        if (!found)
                        begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                    else if (!found || part_size[i] <= part_size[pick])
                    begin
                        // equal sizes: the later index wins
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found)
            begin
                part_busy[pick]  = 1'b1;
                part_owner[pick] = w.owner_id;
                r.outcome        = OUT_ALLOCATED;
                r.chosen_block   = SLOT_IDX_W'(pick);
            end
            else
            begin
                r.outcome = OUT_NO_SPACE;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if (part_busy[i] && part_owner[i] == w.owner_id)
                begin
                    part_busy[i] = 1'b0;
                    freed++;
                end
            end
            r.outcome     = (freed != 0) ? OUT_RELEASED : OUT_NONE_OWNED;
            r.freed_count = COUNT_W'(freed);
        end
        return r;
    endfunction

    function automatic int rand_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_word_t make_word(input logic op, input logic policy,
                                           input int owner, input int req_size);
        in_word_t w;
        w.op           = op;
        w.policy       = policy;
        w.owner_id     = OWNER_W'(owner);
        w.request_size = SIZE_W'(req_size);
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = rand_gap(sender_gaps_on);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_outcomes.push_back(apply_request(w));
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input int idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= SLOT_IDX_W'(idx);
        cfg_data  <= SIZE_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        part_size[idx] = SIZE_W'(value);
    endtask

    // Receiver: hold ready low for random stretches.
    initial
    begin : receiver_stall
        int hold_cycles;
        hold_cycles = 0;
        out_ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready   <= 1'b1;
                hold_cycles = rand_gap(receiver_stalls_on);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result word with none expected: outcome %0d block %0d freed %0d",
                         $time, out_data.outcome, out_data.chosen_block,
                         out_data.freed_count);
                mismatch_count++;
            end
            else
            begin
                oldest_outcome = pending_outcomes.pop_front();
                if (out_data.outcome !== oldest_outcome.outcome)
                begin
                    $display("%0t: outcome expected %0d actual %0d", $time,
                             oldest_outcome.outcome, out_data.outcome);
                    mismatch_count++;
                end
                if (out_data.chosen_block !== oldest_outcome.chosen_block)
                begin
                    $display("%0t: chosen_block expected %0d actual %0d", $time,
                             oldest_outcome.chosen_block, out_data.chosen_block);
                    mismatch_count++;
                end
                if (out_data.freed_count !== oldest_outcome.freed_count)
                begin
                    $display("%0t: freed_count expected %0d actual %0d", $time,
                             oldest_outcome.freed_count, out_data.freed_count);
                    mismatch_count++;
                end
            end
        end
    end

    // All partitions absent after reset: nothing fits, nothing to release.
    task automatic test_empty_after_reset();
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 0, 0));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 1023, 0));
        send_word(make_word(OP_RELEASE, POLICY_FIRST, 0, 0));
    endtask

    task automatic test_first_fit();
        int layout [MAX_SLOTS];
        layout = '{100, 0, 50, 65535, 50, 200, 1, 65535};
        wait_drained();
        for (int i = 0; i < MAX_SLOTS; i++)
            write_size(i, layout[i]);
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 5, 60));
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 5, 60));
        // zero-size request skips the absent block
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 1023, 0));
        // only the last block is left at full size
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 7, 65535));
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 7, 65535));
    endtask

    task automatic test_best_fit();
        send_word(make_word(OP_RELEASE, POLICY_BEST, 5, 65535));
        send_word(make_word(OP_RELEASE, POLICY_FIRST, 7, 0));
        send_word(make_word(OP_RELEASE, POLICY_FIRST, 1023, 0));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 1, 50));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 1, 50));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 2, 1));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 2, 150));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 3, 65535));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 3, 65535));
        send_word(make_word(OP_ALLOC, POLICY_BEST, 3, 0));
        // every present block is busy now
        send_word(make_word(OP_ALLOC, POLICY_BEST, 4, 0));
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 4, 0));
    endtask

    // Shrink a busy block to absent; release must still free it.
    task automatic test_resize_busy();
        wait_drained();
        write_size(3, 0);
        write_size(1, 65535);
        send_word(make_word(OP_RELEASE, POLICY_FIRST, 3, 0));
        send_word(make_word(OP_RELEASE, POLICY_BEST, 3, 0));
        send_word(make_word(OP_ALLOC, POLICY_FIRST, 0, 65535));
    endtask

    function automatic int rand_size(input int profile);
        int r;
        r = $urandom_range(0, 99);
        case (profile)
            0: return $urandom_range(0, 65535);
            1:
            begin
                if (r < 20)
                    return 0;
                if (r < 30)
                    return 65535;
                return $urandom_range(1, 64);
            end
            2: return (r < 25) ? 0 : 65535;
            default: return (r < 40) ? 0 : $urandom_range(1, 1000);
        endcase
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        int       r;
        int       s;
        w.op     = ($urandom_range(0, 99) < 25) ? OP_RELEASE : OP_ALLOC;
        w.policy = $urandom_range(0, 1) ? POLICY_BEST : POLICY_FIRST;
        // a small owner pool lets releases find their blocks
        w.owner_id = ($urandom_range(0, 99) < 85) ? OWNER_W'($urandom_range(0, 7))
                                                   : OWNER_W'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 8)
            s = 0;
        else if (r < 14)
            s = 65535;
        else if (r < 70)
        begin
            // aim at, just under or just over a configured size
            s = int'(part_size[$urandom_range(0, MAX_SLOTS - 1)]) + $urandom_range(0, 2) - 1;
            if (s < 0)
                s = 0;
            if (s > 65535)
                s = 65535;
        end
        else
            s = $urandom_range(0, 65535);
        w.request_size = SIZE_W'(s);
        return w;
    endfunction

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_drained();
            sender_gaps_on     = (phase % 4 != 3);
            receiver_stalls_on = (phase % 4 != 3);
            for (int i = 0; i < MAX_SLOTS; i++)
                write_size(i, rand_size(phase % 4));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (phase == 5 && n == PHASE_WORDS / 2)
                    wait_drained();
                send_word(rand_word());
            end
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        in_data            = '0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        mismatch_count     = 0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            part_size[i]  = '0;
            part_busy[i]  = 1'b0;
            part_owner[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_after_reset();
        test_first_fit();
        test_best_fit();
        test_resize_busy();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== partition_allocator_first_best_fit.f =====
design/pafbf_pkg.sv
design/pafbf_ctrl.sv
design/pafbf_dp.sv
design/partition_allocator_first_best_fit.sv
tb/tb_top.sv
